// File: sv/lpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the lifted product parity entry block
package lpp_pkg;

   localparam int LIFT_W     = 7;
   localparam int DIM_W      = 4;
   localparam int IDX_W      = 13;
   localparam int EXP_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam int PROD_W = 2 * DIM_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int LIM_W  = LIFT_W + SUM_W;

   localparam int DEF_MAX_LIFT = 64;
   localparam int DEF_MAX_DIM  = 8;

   localparam logic [LIFT_W-1:0] LIFT_RESET = LIFT_W'(64);
   localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(1);

   // two quotient bits per cycle
   localparam int DIV_CYCLES = (IDX_W + 1) / 2;
   localparam int DIV_PAD_W  = 2 * DIV_CYCLES;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   typedef enum logic [1:0] {
      REQ_TOGGLE_A = 2'd0,
      REQ_TOGGLE_B = 2'd1,
      REQ_QUERY_X  = 2'd2,
      REQ_QUERY_Z  = 2'd3
   } lpp_req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIFT_SIZE = 3'd0,
      CSR_A_ROWS    = 3'd1,
      CSR_A_COLS    = 3'd2,
      CSR_B_ROWS    = 3'd3,
      CSR_B_COLS    = 3'd4
   } lpp_csr_type;

   typedef enum logic {
      RSP_OK      = 1'b0,
      RSP_INVALID = 1'b1
   } lpp_status_type;

   typedef struct packed {
      logic capture;
      logic div_load1;
      logic div_load2;
      logic div_step;
      logic tog_read;
      logic query_read;
      logic tog_write;
      logic res_bad;
      logic res_query;
      logic res_toggle;
   } lpp_cmd_type;

   typedef struct packed {
      logic is_toggle;
      logic ok;
   } lpp_sts_type;

endpackage
`default_nettype wire

// File: sv/lpp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider lane, two quotient bits per cycle while step is asserted
module lpp_div (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic                      step,
   input  wire logic [lpp_pkg::IDX_W-1:0]  dividend,
   input  wire logic [lpp_pkg::LIFT_W-1:0] divisor,
   output logic      [lpp_pkg::IDX_W-1:0]  quotient,
   output logic      [lpp_pkg::LIFT_W-1:0] remainder
);
   import lpp_pkg::*;

   logic [DIV_PAD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_PAD_W-1:0] quo_ff, quo_in;
   logic [LIFT_W-1:0]    rem_ff, rem_in;
   logic [LIFT_W-1:0]    dvs_ff;
   logic [LIFT_W:0]      trial;

   always_comb begin
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, dvd_in[DIV_PAD_W-1]};
         dvd_in = {dvd_in[DIV_PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial  = trial - {1'b0, dvs_ff};
            quo_in = {quo_in[DIV_PAD_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[DIV_PAD_W-2:0], 1'b0};
         end
         rem_in = trial[LIFT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dvd_ff <= DIV_PAD_W'(dividend);
         quo_ff <= '0;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (step) begin
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff[IDX_W-1:0];
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: sv/lpp_store.sv
`timescale 1ns / 1ps
`default_nettype none
// polynomial word memory with per-entry valid bits, unwritten entries read as zero
module lpp_store #(
   parameter  int WIDTH  = 64,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic      [WIDTH-1:0]  rd_word
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic             rd_valid_ff;
   logic [WIDTH-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_word = rd_valid_ff ? rd_word_ff : '0;

endmodule
`default_nettype wire

// File: sv/lpp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// datapath: configuration, bounds, divider lanes, polynomial stores and result register
module lpp_dp #(
   parameter int MAX_LIFT = lpp_pkg::DEF_MAX_LIFT,
   parameter int MAX_DIM  = lpp_pkg::DEF_MAX_DIM
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [lpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lpp_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic [1:0]                     req_type,
   input  wire logic [lpp_pkg::IDX_W-1:0]      req_row_index,
   input  wire logic [lpp_pkg::IDX_W-1:0]      req_col_index,
   input  wire logic [lpp_pkg::EXP_W-1:0]      req_exponent,
   input  wire lpp_pkg::lpp_cmd_type          cmd,
   output lpp_pkg::lpp_sts_type               sts,
   output logic                               rsp_entry_bit,
   output logic                               rsp_status
);
   import lpp_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIMX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int EIDX_W = (MAX_LIFT > 1) ? $clog2(MAX_LIFT) : 1;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [DIMX_W-1:0] r,
                                                   input logic [DIMX_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM)) + ADDR_W'(c);
   endfunction

   // configuration
   logic [LIFT_W-1:0] lift_ff;
   logic [DIM_W-1:0]  a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff   <= LIFT_RESET;
         a_rows_ff <= DIM_RESET;
         a_cols_ff <= DIM_RESET;
         b_rows_ff <= DIM_RESET;
         b_cols_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LIFT_SIZE: lift_ff   <= csr_wr_data;
            CSR_A_ROWS:    a_rows_ff <= csr_wr_data[DIM_W-1:0];
            CSR_A_COLS:    a_cols_ff <= csr_wr_data[DIM_W-1:0];
            CSR_B_ROWS:    b_rows_ff <= csr_wr_data[DIM_W-1:0];
            CSR_B_COLS:    b_cols_ff <= csr_wr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic dim_ok(input logic [DIM_W-1:0] d);
      return (d != '0) && (32'(d) <= MAX_DIM);
   endfunction

   // bounds, two register stages
   logic              cfg_ok_ff;
   logic [PROD_W-1:0] x_prod_ff, z_prod_ff, left_ff;
   logic [SUM_W-1:0]  col_sum_ff;
   logic [LIM_W-1:0]  x_lim_ff, z_lim_ff, col_lim_ff;

   always_ff @(posedge clock) begin
      cfg_ok_ff  <= (lift_ff != '0) && (32'(lift_ff) <= MAX_LIFT) &&
                    dim_ok(a_rows_ff) && dim_ok(a_cols_ff) &&
                    dim_ok(b_rows_ff) && dim_ok(b_cols_ff);
      x_prod_ff  <= PROD_W'(a_rows_ff) * PROD_W'(b_cols_ff);
      z_prod_ff  <= PROD_W'(a_cols_ff) * PROD_W'(b_rows_ff);
      left_ff    <= PROD_W'(a_cols_ff) * PROD_W'(b_cols_ff);
      col_sum_ff <= SUM_W'(PROD_W'(a_cols_ff) * PROD_W'(b_cols_ff)) +
                    SUM_W'(PROD_W'(a_rows_ff) * PROD_W'(b_rows_ff));
      x_lim_ff   <= LIM_W'(lift_ff) * LIM_W'(x_prod_ff);
      z_lim_ff   <= LIM_W'(lift_ff) * LIM_W'(z_prod_ff);
      col_lim_ff <= LIM_W'(lift_ff) * LIM_W'(col_sum_ff);
   end

   // request capture
   logic [1:0]       type_ff;
   logic [IDX_W-1:0] row_ff, col_ff;
   logic [EXP_W-1:0] exp_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         row_ff  <= req_row_index;
         col_ff  <= req_col_index;
         exp_ff  <= req_exponent;
      end
   end

   logic             is_a, zq, tog_ok, qry_ok;
   logic [DIM_W-1:0] nr, nc;
   logic [LIM_W-1:0] row_lim;

   always_comb begin
      is_a    = (type_ff == REQ_TOGGLE_A);
      zq      = (type_ff == REQ_QUERY_Z);
      nr      = is_a ? a_rows_ff : b_rows_ff;
      nc      = is_a ? a_cols_ff : b_cols_ff;
      row_lim = zq ? z_lim_ff : x_lim_ff;
      tog_ok  = (row_ff < IDX_W'(nr)) && (col_ff < IDX_W'(nc)) &&
                (LIFT_W'(exp_ff) < lift_ff);
      qry_ok  = (LIM_W'(row_ff) < row_lim) && (LIM_W'(col_ff) < col_lim_ff);
      sts.is_toggle = (type_ff == REQ_TOGGLE_A) || (type_ff == REQ_TOGGLE_B);
      sts.ok        = cfg_ok_ff && (sts.is_toggle ? tog_ok : qry_ok);
   end

   // divider lanes: first pass by lift size, second pass by block dims
   logic [IDX_W-1:0]  quo0, quo1, dvd0, dvd1;
   logic [LIFT_W-1:0] rem0, rem1, dvs0, dvs1;
   logic              is_left, is_left_ff;
   logic [LIFT_W-1:0] dx, dz, dist_ff;

   always_comb begin
      is_left = (quo1 < IDX_W'(left_ff));
      dx = (rem0 >= rem1) ? (rem0 - rem1) : (rem0 - rem1 + lift_ff);
      dz = (rem1 >= rem0) ? (rem1 - rem0) : (rem1 - rem0 + lift_ff);
      if (cmd.div_load1) begin
         dvd0 = row_ff;
         dvs0 = lift_ff;
         dvd1 = col_ff;
         dvs1 = lift_ff;
      end else begin
         dvd0 = quo0;
         dvs0 = LIFT_W'(zq ? b_rows_ff : b_cols_ff);
         dvd1 = is_left ? quo1 : (quo1 - IDX_W'(left_ff));
         dvs1 = LIFT_W'(is_left ? b_cols_ff : b_rows_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load2) begin
         is_left_ff <= is_left;
         dist_ff    <= zq ? dz : dx;
      end
   end

   lpp_div u_div_row (
      .clock     (clock),
      .load      (cmd.div_load1 | cmd.div_load2),
      .step      (cmd.div_step),
      .dividend  (dvd0),
      .divisor   (dvs0),
      .quotient  (quo0),
      .remainder (rem0)
   );

   lpp_div u_div_col (
      .clock     (clock),
      .load      (cmd.div_load1 | cmd.div_load2),
      .step      (cmd.div_step),
      .dividend  (dvd1),
      .divisor   (dvs1),
      .quotient  (quo1),
      .remainder (rem1)
   );

   // stores
   logic [ADDR_W-1:0]   tog_addr, qa_addr, qb_addr, rd_addr_a, rd_addr_b;
   logic [MAX_LIFT-1:0] word_a, word_b, old_word, flip;
   logic                rd_en, wr_a, wr_b;

   always_comb begin
      tog_addr  = word_addr(row_ff[DIMX_W-1:0], col_ff[DIMX_W-1:0]);
      qa_addr   = zq ? word_addr(quo1[DIMX_W-1:0], quo0[DIMX_W-1:0])
                     : word_addr(quo0[DIMX_W-1:0], quo1[DIMX_W-1:0]);
      qb_addr   = zq ? word_addr(rem0[DIMX_W-1:0], rem1[DIMX_W-1:0])
                     : word_addr(rem1[DIMX_W-1:0], rem0[DIMX_W-1:0]);
      rd_addr_a = cmd.tog_read ? tog_addr : qa_addr;
      rd_addr_b = cmd.tog_read ? tog_addr : qb_addr;
      rd_en     = cmd.tog_read | cmd.query_read;
      old_word  = is_a ? word_a : word_b;
      flip      = MAX_LIFT'(1) << exp_ff[EIDX_W-1:0];
      wr_a      = cmd.tog_write && is_a;
      wr_b      = cmd.tog_write && !is_a;
   end

   lpp_store #(.WIDTH(MAX_LIFT), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .wr_en   (wr_a),
      .wr_addr (tog_addr),
      .wr_data (old_word ^ flip),
      .rd_word (word_a)
   );

   lpp_store #(.WIDTH(MAX_LIFT), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .wr_en   (wr_b),
      .wr_addr (tog_addr),
      .wr_data (old_word ^ flip),
      .rd_word (word_b)
   );

   // result
   logic                sel_b, match;
   logic [MAX_LIFT-1:0] q_word;

   always_comb begin
      sel_b  = zq ^ !is_left_ff;
      match  = (zq ^ is_left_ff) ? (rem0 == rem1) : (quo0 == quo1);
      q_word = sel_b ? word_b : word_a;
   end

   logic entry_bit_ff, status_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_bad) begin
         entry_bit_ff <= 1'b0;
         status_ff    <= RSP_INVALID;
      end else if (cmd.res_query) begin
         entry_bit_ff <= match & q_word[dist_ff[EIDX_W-1:0]];
         status_ff    <= RSP_OK;
      end else if (cmd.res_toggle) begin
         entry_bit_ff <= ~old_word[exp_ff[EIDX_W-1:0]];
         status_ff    <= RSP_OK;
      end
   end

   assign rsp_entry_bit = entry_bit_ff;
   assign rsp_status    = status_ff;

endmodule
`default_nettype wire

// File: sv/lpp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// controller: request sequencing and result handshake
module lpp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire lpp_pkg::lpp_sts_type sts,
   output lpp_pkg::lpp_cmd_type      cmd
);
   import lpp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP1,
      S_SETUP2,
      S_CHECK,
      S_DIV1,
      S_LOAD2,
      S_DIV2,
      S_LOOKUP,
      S_QRES,
      S_TWR
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free, last;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      last         = (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_SETUP1;
            end
         end
         S_SETUP1: state_in = S_SETUP2;
         S_SETUP2: state_in = S_CHECK;
         S_CHECK: begin
            if (!sts.ok) begin
               if (slot_free) begin
                  cmd.res_bad  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (sts.is_toggle) begin
               cmd.tog_read = 1'b1;
               state_in     = S_TWR;
            end else begin
               cmd.div_load1 = 1'b1;
               cnt_in        = '0;
               state_in      = S_DIV1;
            end
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (last) begin
               state_in = S_LOAD2;
            end
         end
         S_LOAD2: begin
            cmd.div_load2 = 1'b1;
            cnt_in        = '0;
            state_in      = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (last) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.query_read = 1'b1;
            state_in       = S_QRES;
         end
         S_QRES: begin
            if (slot_free) begin
               cmd.res_query = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_TWR: begin
            if (slot_free) begin
               cmd.tog_write  = 1'b1;
               cmd.res_toggle = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: sv/lifted_product_parity_entry.sv
`timescale 1ns / 1ps
`default_nettype none
// top level of the lifted product parity-check entry unit
//
//   channel  ports                                           transfer
//   req      req_valid req_ready req_type req_row_index      valid & ready
//            req_col_index req_exponent
//   rsp      rsp_valid rsp_ready rsp_entry_bit rsp_status    valid & ready
//   csr      csr_wr_en csr_index csr_wr_data                 csr_wr_en
//
// one request at a time; a query runs two passes of the two-bit-per-cycle divider
// lanes, then a store lookup
// a toggle is a read-modify-write of one store word
// the result register holds one result; a new request is taken while it waits
// reset clears configuration, control and the store valid bits
module lifted_product_parity_entry #(
   parameter int MAX_LIFT = lpp_pkg::DEF_MAX_LIFT,
   parameter int MAX_DIM  = lpp_pkg::DEF_MAX_DIM
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                     req_type,
   input  wire logic [lpp_pkg::IDX_W-1:0]      req_row_index,
   input  wire logic [lpp_pkg::IDX_W-1:0]      req_col_index,
   input  wire logic [lpp_pkg::EXP_W-1:0]      req_exponent,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_entry_bit,
   output logic                               rsp_status,
   input  wire logic                          csr_wr_en,
   input  wire logic [lpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lpp_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import lpp_pkg::*;

   lpp_cmd_type cmd;
   lpp_sts_type sts;

   lpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpp_dp #(.MAX_LIFT(MAX_LIFT), .MAX_DIM(MAX_DIM)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_type      (req_type),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_exponent  (req_exponent),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_entry_bit (rsp_entry_bit),
      .rsp_status    (rsp_status)
   );

endmodule
`default_nettype wire

// File: dv/tb_lifted_product_parity_entry.sv
`timescale 1ns / 1ps
// self-checking testbench for the lifted product parity entry unit with a local predictor
module tb_lifted_product_parity_entry;
   import lpp_pkg::*;

   localparam int ROW_STRIDE = DEF_MAX_DIM;

   typedef struct packed {
      logic           entry_bit;
      lpp_status_type status;
   } entry_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_type;
   logic [IDX_W-1:0]      req_row_index;
   logic [IDX_W-1:0]      req_col_index;
   logic [EXP_W-1:0]      req_exponent;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_entry_bit;
   logic                  rsp_status;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   logic [LIFT_W-1:0] lift_reg;
   logic [DIM_W-1:0]  a_rows_reg;
   logic [DIM_W-1:0]  a_cols_reg;
   logic [DIM_W-1:0]  b_rows_reg;
   logic [DIM_W-1:0]  b_cols_reg;
   logic [63:0]       poly_a [0:63];
   logic [63:0]       poly_b [0:63];

   entry_result_type pending_entries [$];
   entry_result_type expected_entry;
   int               error_count = 0;
   int               burst_left = 0;
   int               hold_requests = 0;

   lifted_product_parity_entry uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_exponent  (req_exponent),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_entry_bit (rsp_entry_bit),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic dim_valid(input logic [DIM_W-1:0] d);
      return int'(d) >= 1 && int'(d) <= DEF_MAX_DIM;
   endfunction

   function automatic logic setup_valid();
      return int'(lift_reg) >= 1 && int'(lift_reg) <= DEF_MAX_LIFT &&
             dim_valid(a_rows_reg) && dim_valid(a_cols_reg) &&
             dim_valid(b_rows_reg) && dim_valid(b_cols_reg);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] dim_data(input int d);
      return {3'($urandom_range(0, 7)), 4'(d)};
   endfunction

   // predicts the expected result and updates the local polynomial stores on valid toggles
   function automatic entry_result_type predict_entry(input lpp_req_kind_type kind,
                                                      input logic [IDX_W-1:0] row,
                                                      input logic [IDX_W-1:0] col,
                                                      input logic [EXP_W-1:0] ex);
      entry_result_type res;
      int ell, ma, na, mb, nb, nr, nc, rows, left, cols;
      int r, c, e, ir, rr, jr, cc, dx, dz, ia, ib, k, w;
      res.entry_bit = 1'b0;
      res.status    = RSP_INVALID;
      if (setup_valid()) begin
         ell = int'(lift_reg);
         ma  = int'(a_rows_reg);
         na  = int'(a_cols_reg);
         mb  = int'(b_rows_reg);
         nb  = int'(b_cols_reg);
         r   = int'(row);
         c   = int'(col);
         e   = int'(ex);
         if (kind == REQ_TOGGLE_A || kind == REQ_TOGGLE_B) begin
            nr = (kind == REQ_TOGGLE_A) ? ma : mb;
            nc = (kind == REQ_TOGGLE_A) ? na : nb;
            if (r < nr && c < nc && e < ell) begin
               w = r * ROW_STRIDE + c;
               if (kind == REQ_TOGGLE_A) begin
                  poly_a[w][e]  = ~poly_a[w][e];
                  res.entry_bit = poly_a[w][e];
               end else begin
                  poly_b[w][e]  = ~poly_b[w][e];
                  res.entry_bit = poly_b[w][e];
               end
               res.status = RSP_OK;
            end
         end else begin
            rows = ell * ((kind == REQ_QUERY_Z) ? na * mb : ma * nb);
            left = na * nb;
            cols = ell * (left + ma * mb);
            if (r < rows && c < cols) begin
               ir = r / ell;
               rr = r % ell;
               jr = c / ell;
               cc = c % ell;
               dx = (rr + ell - cc) % ell;
               dz = (cc + ell - rr) % ell;
               res.status = RSP_OK;
               if (kind == REQ_QUERY_X) begin
                  ia = ir / nb;
                  ib = ir % nb;
                  if (jr < left) begin
                     if (ib == jr % nb) res.entry_bit = poly_a[ia * ROW_STRIDE + jr / nb][dx];
                  end else begin
                     k = jr - left;
                     if (ia == k / mb) res.entry_bit = poly_b[(k % mb) * ROW_STRIDE + ib][dx];
                  end
               end else begin
                  ia = ir / mb;
                  ib = ir % mb;
                  if (jr < left) begin
                     if (ia == jr / nb) res.entry_bit = poly_b[ib * ROW_STRIDE + jr % nb][dz];
                  end else begin
                     k = jr - left;
                     if (ib == k % mb) res.entry_bit = poly_a[(k / mb) * ROW_STRIDE + ia][dz];
                  end
               end
            end
         end
      end
      return res;
   endfunction

   task automatic send_item(input lpp_req_kind_type kind, input int row, input int col,
                            input int ex);
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_row_index <= IDX_W'(row);
      req_col_index <= IDX_W'(col);
      req_exponent  <= EXP_W'(ex);
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_entries.push_back(predict_entry(kind, IDX_W'(row), IDX_W'(col), EXP_W'(ex)));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid  <= 1'b0;
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic csr_write(input lpp_csr_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_LIFT_SIZE: lift_reg   = data[LIFT_W-1:0];
         CSR_A_ROWS:    a_rows_reg = data[DIM_W-1:0];
         CSR_A_COLS:    a_cols_reg = data[DIM_W-1:0];
         CSR_B_ROWS:    b_rows_reg = data[DIM_W-1:0];
         CSR_B_COLS:    b_cols_reg = data[DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] lift, input logic [CSR_DATA_W-1:0] ar,
                             input logic [CSR_DATA_W-1:0] ac, input logic [CSR_DATA_W-1:0] br,
                             input logic [CSR_DATA_W-1:0] bc);
      wait_idle();
      csr_write(CSR_LIFT_SIZE, lift);
      csr_write(CSR_A_ROWS, ar);
      csr_write(CSR_A_COLS, ac);
      csr_write(CSR_B_ROWS, br);
      csr_write(CSR_B_COLS, bc);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_items(input int n);
      int i, pick, ell, ma, na, mb, nb, left, rows, cols, ir, jr, ia, ib, row, col, ex;
      logic z_check, on_right;
      lpp_req_kind_type kind;
      for (i = 0; i < n; i++) begin
         pick = setup_valid() ? $urandom_range(0, 99) : 99;
         ell  = int'(lift_reg);
         ma   = int'(a_rows_reg);
         na   = int'(a_cols_reg);
         mb   = int'(b_rows_reg);
         nb   = int'(b_cols_reg);
         left = na * nb;
         cols = ell * (left + ma * mb);
         if (pick < 25) begin
            kind = $urandom_range(0, 1) ? REQ_TOGGLE_B : REQ_TOGGLE_A;
            row  = $urandom_range(0, ((kind == REQ_TOGGLE_A) ? ma : mb) - 1);
            col  = $urandom_range(0, ((kind == REQ_TOGGLE_A) ? na : nb) - 1);
            ex   = $urandom_range(0, ell - 1);
         end else if (pick < 65) begin
            // land inside a nonzero block of the lifted matrix
            z_check  = 1'($urandom_range(0, 1));
            on_right = 1'($urandom_range(0, 1));
            if (!z_check) begin
               kind = REQ_QUERY_X;
               ia   = $urandom_range(0, ma - 1);
               ib   = $urandom_range(0, nb - 1);
               ir   = ia * nb + ib;
               if (!on_right) jr = $urandom_range(0, na - 1) * nb + ib;
               else jr = left + ia * mb + $urandom_range(0, mb - 1);
            end else begin
               kind = REQ_QUERY_Z;
               ia   = $urandom_range(0, na - 1);
               ib   = $urandom_range(0, mb - 1);
               ir   = ia * mb + ib;
               if (!on_right) jr = ia * nb + $urandom_range(0, nb - 1);
               else jr = left + $urandom_range(0, ma - 1) * mb + ib;
            end
            row = ir * ell + $urandom_range(0, ell - 1);
            col = jr * ell + $urandom_range(0, ell - 1);
            ex  = $urandom_range(0, 63);
         end else if (pick < 85) begin
            kind = $urandom_range(0, 1) ? REQ_QUERY_Z : REQ_QUERY_X;
            rows = ell * ((kind == REQ_QUERY_Z) ? na * mb : ma * nb);
            row  = $urandom_range(0, rows - 1);
            col  = $urandom_range(0, cols - 1);
            ex   = $urandom_range(0, 63);
         end else begin
            kind = lpp_req_kind_type'($urandom_range(0, 3));
            row  = $urandom_range(0, 8191);
            col  = $urandom_range(0, 8191);
            ex   = $urandom_range(0, 63);
         end
         send_item(kind, row, col, ex);
      end
   endtask

   task automatic test_default_setup();
      send_item(REQ_TOGGLE_A, 0, 0, 0);
      send_item(REQ_TOGGLE_A, 0, 0, 0);
      send_item(REQ_TOGGLE_B, 0, 0, 63);
      send_item(REQ_TOGGLE_A, 1, 0, 0);
      send_item(REQ_QUERY_X, 63, 127, 0);
      send_item(REQ_QUERY_X, 64, 0, 0);
      send_item(REQ_QUERY_Z, 8191, 8191, 63);
      send_item(REQ_QUERY_Z, 0, 64, 0);
   endtask

   task automatic test_largest_setup();
      set_config(7'd64, 7'd8, 7'd8, 7'd8, 7'd8);
      send_item(REQ_TOGGLE_A, 7, 7, 63);
      send_item(REQ_TOGGLE_B, 7, 7, 0);
      send_item(REQ_QUERY_X, 4095, 8191, 0);
      send_item(REQ_QUERY_Z, 4095, 8191, 0);
      send_item(REQ_QUERY_X, 4096, 0, 0);
      send_item(REQ_TOGGLE_B, 8, 0, 0);
   endtask

   task automatic test_bad_setup();
      set_config(7'd0, 7'd1, 7'd1, 7'd1, 7'd1);
      send_item(REQ_QUERY_X, 0, 0, 0);
      send_item(REQ_TOGGLE_A, 0, 0, 0);
      set_config(7'd65, 7'd1, 7'd1, 7'd1, 7'd1);
      send_item(REQ_TOGGLE_B, 0, 0, 0);
      set_config(7'd64, 7'd9, 7'd1, 7'd1, 7'd1);
      send_item(REQ_QUERY_Z, 0, 0, 0);
      set_config(7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f);
      send_item(REQ_TOGGLE_A, 0, 0, 0);
   endtask

   task automatic test_stale_coefficients();
      set_config(7'd64, 7'd1, 7'd1, 7'd1, 7'd1);
      send_item(REQ_TOGGLE_A, 0, 0, 40);
      set_config(7'd32, 7'd1, 7'd1, 7'd1, 7'd1);
      send_item(REQ_TOGGLE_A, 0, 0, 40);
      send_item(REQ_QUERY_X, 8, 0, 0);
      set_config(7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
      send_item(REQ_TOGGLE_A, 0, 0, 1);
      send_item(REQ_QUERY_Z, 0, 1, 0);
      set_config(7'd64, 7'd1, 7'd1, 7'd1, 7'd1);
      send_item(REQ_QUERY_X, 40, 0, 0);
   endtask

   task automatic test_backpressure();
      set_config(7'd16, 7'd2, 7'd3, 7'd2, 7'd2);
      hold_requests++;
      random_items(30);
   endtask

   task automatic test_random_phases();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         case (phase) inside
            0: set_config(7'd64, 7'd8, 7'd8, 7'd8, 7'd8);
            1: set_config(7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
            2, 6: set_config(CSR_DATA_W'($urandom_range(1, 8)), dim_data($urandom_range(1, 3)),
                             dim_data($urandom_range(1, 3)), dim_data($urandom_range(1, 3)),
                             dim_data($urandom_range(1, 3)));
            4: begin
               case ($urandom_range(0, 3))
                  0: set_config(7'd0, dim_data(2), dim_data(2), dim_data(2), dim_data(2));
                  1: set_config(CSR_DATA_W'($urandom_range(65, 127)), dim_data(2), dim_data(2),
                                dim_data(2), dim_data(2));
                  2: set_config(7'd8, dim_data(2), dim_data(0), dim_data(2), dim_data(2));
                  default: set_config(7'd8, dim_data(2), dim_data(2), dim_data(2),
                                      dim_data($urandom_range(9, 15)));
               endcase
            end
            5: set_config(7'd64, 7'd1, 7'd8, 7'd8, 7'd1);
            default: set_config(CSR_DATA_W'($urandom_range(1, 64)),
                                dim_data($urandom_range(1, 8)),
                                dim_data($urandom_range(1, 8)), dim_data($urandom_range(1, 8)),
                                dim_data($urandom_range(1, 8)));
         endcase
         case (phase)
            0: random_items(200);
            1: random_items(100);
            4: random_items(40);
            5: random_items(150);
            default: random_items(190);
         endcase
      end
   endtask

   // result receiver: random stall patterns, plus a long hold-off on request
   initial begin : rsp_drive
      int hold_left, phase_left, holds_seen;
      logic [7:0] pattern;
      hold_left  = 0;
      phase_left = 0;
      holds_seen = 0;
      pattern    = 8'hff;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(16, 96);
               case ($urandom_range(0, 3))
                  0: pattern = 8'hff;
                  1: pattern = 8'($urandom_range(0, 255));
                  2: pattern = 8'h11;
                  default: pattern = 8'hee;
               endcase
            end
            phase_left--;
            rsp_ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_entries.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected transfer: entry_bit=%0b status=%0b",
                        rsp_entry_bit, rsp_status);
         end else begin
            expected_entry = pending_entries.pop_front();
            if (rsp_entry_bit !== expected_entry.entry_bit ||
                rsp_status !== expected_entry.status) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected entry_bit=%0b status=%0b, got %0b %0b",
                           expected_entry.entry_bit, expected_entry.status,
                           rsp_entry_bit, rsp_status);
            end
         end
      end
   end

   initial begin : main_sequence
      int i;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= REQ_TOGGLE_A;
      req_row_index <= '0;
      req_col_index <= '0;
      req_exponent  <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_LIFT_SIZE;
      csr_wr_data   <= '0;
      lift_reg   = LIFT_RESET;
      a_rows_reg = DIM_RESET;
      a_cols_reg = DIM_RESET;
      b_rows_reg = DIM_RESET;
      b_cols_reg = DIM_RESET;
      for (i = 0; i < 64; i++) begin
         poly_a[i] = '0;
         poly_b[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_setup();
      test_largest_setup();
      test_bad_setup();
      test_stale_coefficients();
      test_backpressure();
      test_random_phases();
      wait_idle();
      if (pending_entries.size() != 0) error_count += pending_entries.size();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
